[design/gillespie_ssa_gene_network_step_assert.svh]
// Assertion macros used by the block's top module.
`ifndef GILLESPIE_SSA_GENE_NETWORK_STEP_ASSERT_SVH
`define GILLESPIE_SSA_GENE_NETWORK_STEP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GSSA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define GSSA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/gssa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package gssa_pkg;

   localparam int NUM_REACTIONS = 9;
   localparam int NUM_SPECIES   = 5;
   localparam int RATE_W        = 32;
   localparam int PROP_W        = 60;
   localparam int MUL_A_W       = 64;
   localparam int MUL_B_W       = 32;
   localparam int PRODUCT_W     = 96;

   localparam logic [PROP_W-1:0] PROP_MAX = {PROP_W{1'b1}};
   localparam logic [31:0]       LN2_Q32  = 32'd2977044472;
   localparam logic [3:0]        NONE_FIRED = 4'd9;

   // Configuration register indexes.
   localparam logic [2:0] REG_ON_OFF       = 3'd0;
   localparam logic [2:0] REG_TX_TL        = 3'd1;
   localparam logic [2:0] REG_BIND_UNBIND  = 3'd2;
   localparam logic [2:0] REG_ACT_MDECAY   = 3'd3;
   localparam logic [2:0] REG_PDECAY       = 3'd4;
   localparam logic [2:0] REG_IDLE_STEP    = 3'd5;

   localparam int SP_OFF   = 0;
   localparam int SP_ON    = 1;
   localparam int SP_MRNA  = 2;
   localparam int SP_PROT  = 3;
   localparam int SP_BOUND = 4;

   typedef logic [1:0] change_type;
   localparam change_type CHG_NONE = 2'd0;
   localparam change_type CHG_INC  = 2'd1;
   localparam change_type CHG_DEC  = 2'd2;

   localparam change_type CHANGE_TABLE [NUM_REACTIONS][NUM_SPECIES] = '{
      '{CHG_DEC,  CHG_INC,  CHG_NONE, CHG_NONE, CHG_NONE},
      '{CHG_INC,  CHG_DEC,  CHG_NONE, CHG_NONE, CHG_NONE},
      '{CHG_NONE, CHG_NONE, CHG_INC,  CHG_NONE, CHG_NONE},
      '{CHG_NONE, CHG_NONE, CHG_NONE, CHG_INC,  CHG_NONE},
      '{CHG_DEC,  CHG_NONE, CHG_NONE, CHG_DEC,  CHG_INC },
      '{CHG_INC,  CHG_NONE, CHG_NONE, CHG_INC,  CHG_DEC },
      '{CHG_NONE, CHG_NONE, CHG_INC,  CHG_NONE, CHG_NONE},
      '{CHG_NONE, CHG_NONE, CHG_DEC,  CHG_NONE, CHG_NONE},
      '{CHG_NONE, CHG_NONE, CHG_NONE, CHG_DEC,  CHG_NONE}
   };

   typedef struct packed {
      logic busy;
      logic done;
   } mul_status_type;

endpackage
`default_nettype wire

[design/gssa_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module gssa_serial_mul (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire  [gssa_pkg::MUL_A_W-1:0] a,
   input  wire  [gssa_pkg::MUL_B_W-1:0] b,
   output gssa_pkg::mul_status_type     status,
   output logic [gssa_pkg::PRODUCT_W-1:0] product
);
   import gssa_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic [PRODUCT_W-1:0] a_ff, a_in, acc_ff, acc_in;
   logic [MUL_B_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;

   // One multiplier bit per cycle: shift-and-add, exact product.
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         a_in   = PRODUCT_W'(a);
         b_in   = b;
         acc_in = '0;
         cnt_in = CNT_W'(MUL_B_W);
      end else if (cnt_ff != '0) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in    = a_ff << 1;
         b_in    = b_ff >> 1;
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;
   assign product     = acc_ff;

endmodule
`default_nettype wire

[design/gillespie_ssa_gene_network_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// One direct-method stochastic simulation step per request transaction for a
// five-species, nine-reaction gene network. The block holds the species counts,
// forms each mass-action propensity on a bit-serial shift-and-add multiplier,
// picks the first reaction whose cumulative propensity exceeds rand_pick times
// the total, applies its count changes with saturation and returns the waiting
// time -ln(rand_time)/total in Q16.16 in one response transaction. A step makes
// ten passes through the shared serial multiplier (each a start and then a
// shift-and-add per multiplier bit; nine propensities, the binding term needing
// two), one pass for the pick threshold, a cumulative scan over up to nine
// reactions, up to 31 normalize shifts plus a check, 32 squaring rounds for the
// logarithm, one pass to scale by ln 2, bit-serial restoring division over 46
// dividend bits, then a saturate step and the hand-over of the result. A step
// with zero total propensity goes from the propensity passes straight to the
// hand-over and reports the idle time step. One step is worked at a time; the
// next request is taken as soon as the result has moved into the response
// register.
module gillespie_ssa_gene_network_step #(
   parameter int COUNT_WIDTH = 16,
   parameter int RAND_WIDTH  = 32
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_rand_time,
   input  wire  [31:0] req_rand_pick,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [3:0]  rsp_reaction_index,
   output logic [31:0] rsp_time_step,
   output logic [15:0] rsp_promoter_off_count,
   output logic [15:0] rsp_promoter_on_count,
   output logic [15:0] rsp_mrna_count,
   output logic [15:0] rsp_protein_count,
   output logic [15:0] rsp_bound_complex_count,
   output logic        rsp_count_saturated,
   input  wire         csr_write_enable,
   input  wire  [2:0]  csr_index,
   input  wire  [63:0] csr_write_data
);
   import gssa_pkg::*;

   `include "gillespie_ssa_gene_network_step_assert.svh"

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_PROP    = 4'd1;
   localparam logic [3:0] S_PWAIT   = 4'd2;
   localparam logic [3:0] S_THR     = 4'd3;
   localparam logic [3:0] S_TWAIT   = 4'd4;
   localparam logic [3:0] S_SCAN    = 4'd5;
   localparam logic [3:0] S_NORM    = 4'd6;
   localparam logic [3:0] S_SQR     = 4'd7;
   localparam logic [3:0] S_LN      = 4'd8;
   localparam logic [3:0] S_LWAIT   = 4'd9;
   localparam logic [3:0] S_DIV     = 4'd10;
   localparam logic [3:0] S_DIVEND  = 4'd11;
   localparam logic [3:0] S_FIN     = 4'd12;

   localparam int DVD_W = 46;   // ln value is 38 bits, shifted up by 8
   localparam int LN_W  = 38;
   localparam logic [RAND_WIDTH-1:0] RAND_ONE = RAND_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // Configuration registers.
   logic [63:0] on_off_ff, tx_tl_ff, bind_ff, act_md_ff;
   logic [31:0] pdecay_ff, idle_step_ff;

   // Control and datapath registers.
   logic [3:0]  state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic        second_ff, second_in;
   logic [COUNT_WIDTH-1:0] counts_ff [NUM_SPECIES];
   logic [COUNT_WIDTH-1:0] counts_in [NUM_SPECIES];
   logic [PROP_W-1:0] prop_ff [NUM_REACTIONS];
   logic [PROP_W-1:0] prop_wr;
   logic        prop_we;
   logic [RAND_WIDTH-1:0] rpick_ff, rpick_in;
   logic [63:0] total_ff, total_in, cum_ff, cum_in, cum_next;
   logic [PRODUCT_W-1:0] thr_ff, thr_in, cum_shifted;
   logic [3:0]  fired_ff, fired_in;
   logic [31:0] y_ff, y_in, frac_ff, frac_in;
   logic [63:0] square;
   logic [32:0] sq_top;
   logic [5:0]  shift_ff, shift_in, round_ff, round_in, int_part;
   logic [LN_W-1:0] log2_val;
   logic [63:0] rem_ff, rem_in;
   logic [64:0] trial;
   logic [DVD_W-1:0] dvd_ff, dvd_in, quo_ff, quo_in;
   logic [5:0]  dcnt_ff, dcnt_in;
   logic [31:0] step_ff, step_in;
   logic        sat_any;

   // Response register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  out_index_ff;
   logic [31:0] out_step_ff;
   logic [15:0] out_counts_ff [NUM_SPECIES];
   logic        out_sat_ff;
   logic        out_load;

   // Shared multiplier.
   logic                 mul_start;
   logic [MUL_A_W-1:0]   mul_a;
   logic [MUL_B_W-1:0]   mul_b;
   mul_status_type       mul_status;
   logic [PRODUCT_W-1:0] mul_product;
   logic [PROP_W-1:0]    capped;
   logic [RATE_W-1:0]    rate_sel;
   logic [COUNT_WIDTH-1:0] count_sel;

   logic req_accept;
   logic [RAND_WIDTH-1:0] rtime_masked;

   gssa_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .status  (mul_status),
      .product (mul_product)
   );

   assign req_stall    = (state_ff != S_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign rtime_masked = req_rand_time[RAND_WIDTH-1:0];

   // Rate constant and species count of each propensity term.
   always_comb begin
      case (idx_ff)
         4'd0: begin rate_sel = on_off_ff[63:32]; count_sel = counts_ff[SP_OFF];   end
         4'd1: begin rate_sel = on_off_ff[31:0];  count_sel = counts_ff[SP_ON];    end
         4'd2: begin rate_sel = tx_tl_ff[63:32];  count_sel = counts_ff[SP_ON];    end
         4'd3: begin rate_sel = tx_tl_ff[31:0];   count_sel = counts_ff[SP_MRNA];  end
         4'd4: begin rate_sel = bind_ff[63:32];   count_sel = counts_ff[SP_OFF];   end
         4'd5: begin rate_sel = bind_ff[31:0];    count_sel = counts_ff[SP_BOUND]; end
         4'd6: begin rate_sel = act_md_ff[63:32]; count_sel = counts_ff[SP_BOUND]; end
         4'd7: begin rate_sel = act_md_ff[31:0];  count_sel = counts_ff[SP_MRNA];  end
         default: begin rate_sel = pdecay_ff;     count_sel = counts_ff[SP_PROT];  end
      endcase
   end

   // Any product at or above 2^60 saturates the propensity.
   assign capped = (mul_product[PRODUCT_W-1:PROP_W] != '0) ? PROP_MAX
                                                           : mul_product[PROP_W-1:0];

   assign cum_next    = cum_ff + 64'(prop_ff[idx_ff]);
   assign cum_shifted = PRODUCT_W'(cum_next) << RAND_WIDTH;
   assign square      = 64'(y_ff) * 64'(y_ff);
   assign sq_top      = square[63:31];
   assign int_part    = 6'(RAND_WIDTH) - 6'd31 + shift_ff;
   assign log2_val    = {int_part, 32'b0} - {6'b0, frac_ff};
   assign trial       = {rem_ff, dvd_ff[DVD_W-1]};

   assign out_load = (state_ff == S_FIN) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      second_in = second_ff;
      rpick_in  = rpick_ff;
      total_in  = total_ff;
      cum_in    = cum_ff;
      thr_in    = thr_ff;
      fired_in  = fired_ff;
      y_in      = y_ff;
      frac_in   = frac_ff;
      shift_in  = shift_ff;
      round_in  = round_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      dcnt_in   = dcnt_ff;
      step_in   = step_ff;
      mul_start = 1'b0;
      mul_a     = {32'b0, rate_sel};
      mul_b     = MUL_B_W'(count_sel);
      prop_we   = 1'b0;
      prop_wr   = capped;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rpick_in  = req_rand_pick[RAND_WIDTH-1:0];
               // A zero time fraction is treated as one LSB.
               y_in      = 32'((rtime_masked == '0) ? RAND_ONE : rtime_masked);
               idx_in    = 4'd0;
               second_in = 1'b0;
               total_in  = '0;
               shift_in  = '0;
               state_in  = S_PROP;
            end
         end
         S_PROP: begin
            mul_start = 1'b1;
            if (second_ff) begin
               // Binding term: (kbind * off) times free protein.
               mul_a = mul_product[MUL_A_W-1:0];
               mul_b = MUL_B_W'(counts_ff[SP_PROT]);
            end
            state_in = S_PWAIT;
         end
         S_PWAIT: begin
            if (mul_status.done) begin
               if ((idx_ff == 4'd4) && !second_ff) begin
                  second_in = 1'b1;
                  state_in  = S_PROP;
               end else begin
                  prop_we   = 1'b1;
                  total_in  = total_ff + 64'(capped);
                  second_in = 1'b0;
                  if (idx_ff == 4'(NUM_REACTIONS - 1)) begin
                     state_in = S_THR;
                  end else begin
                     idx_in   = idx_ff + 1'b1;
                     state_in = S_PROP;
                  end
               end
            end
         end
         S_THR: begin
            if (total_ff == '0) begin
               fired_in = NONE_FIRED;
               step_in  = idle_step_ff;
               state_in = S_FIN;
            end else begin
               mul_start = 1'b1;
               mul_a     = total_ff;
               mul_b     = MUL_B_W'(rpick_ff);
               state_in  = S_TWAIT;
            end
         end
         S_TWAIT: begin
            if (mul_status.done) begin
               thr_in   = mul_product;
               idx_in   = 4'd0;
               cum_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cum_in = cum_next;
            if (cum_shifted > thr_ff) begin
               fired_in = idx_ff;
               state_in = S_NORM;
            end else if (idx_ff == 4'(NUM_REACTIONS - 1)) begin
               fired_in = NONE_FIRED;
               state_in = S_NORM;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_NORM: begin
            if (y_ff[31]) begin
               round_in = '0;
               frac_in  = '0;
               state_in = S_SQR;
            end else begin
               y_in     = y_ff << 1;
               shift_in = shift_ff + 1'b1;
            end
         end
         S_SQR: begin
            // One fractional bit of log2 per squaring of the Q1.31 mantissa.
            if (sq_top[32]) begin
               y_in    = sq_top[32:1];
               frac_in = {frac_ff[30:0], 1'b1};
            end else begin
               y_in    = sq_top[31:0];
               frac_in = {frac_ff[30:0], 1'b0};
            end
            round_in = round_ff + 1'b1;
            if (round_ff == 6'd31) begin
               state_in = S_LN;
            end
         end
         S_LN: begin
            mul_start = 1'b1;
            mul_a     = 64'(log2_val);
            mul_b     = LN2_Q32;
            state_in  = S_LWAIT;
         end
         S_LWAIT: begin
            if (mul_status.done) begin
               dvd_in   = {mul_product[LN_W+31:32], 8'b0};
               rem_in   = '0;
               quo_in   = '0;
               dcnt_in  = 6'(DVD_W);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // The partial remainder stays below the total, so 64 bits hold it.
            if (trial >= {1'b0, total_ff}) begin
               rem_in = 64'(trial - {1'b0, total_ff});
               quo_in = {quo_ff[DVD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[63:0];
               quo_in = {quo_ff[DVD_W-2:0], 1'b0};
            end
            dvd_in  = dvd_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 6'd1) begin
               state_in = S_DIVEND;
            end
         end
         S_DIVEND: begin
            step_in  = (quo_ff[DVD_W-1:32] != '0) ? 32'hFFFF_FFFF : quo_ff[31:0];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Count changes of the fired reaction, clipped at zero and at full scale.
   always_comb begin
      sat_any = 1'b0;
      for (int s = 0; s < NUM_SPECIES; s++) begin
         counts_in[s] = counts_ff[s];
         if (fired_ff != NONE_FIRED) begin
            case (CHANGE_TABLE[fired_ff][s])
               CHG_INC: begin
                  if (counts_ff[s] == COUNT_MAX) sat_any = 1'b1;
                  else counts_in[s] = counts_ff[s] + 1'b1;
               end
               CHG_DEC: begin
                  if (counts_ff[s] == '0) sat_any = 1'b1;
                  else counts_in[s] = counts_ff[s] - 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         on_off_ff    <= '0;
         tx_tl_ff     <= '0;
         bind_ff      <= '0;
         act_md_ff    <= '0;
         pdecay_ff    <= '0;
         idle_step_ff <= 32'd6554;
         for (int s = 0; s < NUM_SPECIES; s++) begin
            counts_ff[s] <= (s == SP_ON) ? COUNT_WIDTH'(1) : '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               REG_ON_OFF:      on_off_ff    <= csr_write_data;
               REG_TX_TL:       tx_tl_ff     <= csr_write_data;
               REG_BIND_UNBIND: bind_ff      <= csr_write_data;
               REG_ACT_MDECAY:  act_md_ff    <= csr_write_data;
               REG_PDECAY:      pdecay_ff    <= csr_write_data[31:0];
               REG_IDLE_STEP:   idle_step_ff <= csr_write_data[31:0];
               default: begin
               end
            endcase
         end
         if (out_load) begin
            for (int s = 0; s < NUM_SPECIES; s++) begin
               counts_ff[s] <= counts_in[s];
            end
         end
      end
      idx_ff    <= idx_in;
      second_ff <= second_in;
      rpick_ff  <= rpick_in;
      total_ff  <= total_in;
      cum_ff    <= cum_in;
      thr_ff    <= thr_in;
      fired_ff  <= fired_in;
      y_ff      <= y_in;
      frac_ff   <= frac_in;
      shift_ff  <= shift_in;
      round_ff  <= round_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      step_ff   <= step_in;
      if (prop_we) begin
         prop_ff[idx_ff] <= prop_wr;
      end
      if (out_load) begin
         out_index_ff <= fired_ff;
         out_step_ff  <= step_ff;
         out_sat_ff   <= sat_any;
         for (int s = 0; s < NUM_SPECIES; s++) begin
            out_counts_ff[s] <= 16'(counts_in[s]);
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_reaction_index      = out_index_ff;
   assign rsp_time_step           = out_step_ff;
   assign rsp_promoter_off_count  = out_counts_ff[SP_OFF];
   assign rsp_promoter_on_count   = out_counts_ff[SP_ON];
   assign rsp_mrna_count          = out_counts_ff[SP_MRNA];
   assign rsp_protein_count       = out_counts_ff[SP_PROT];
   assign rsp_bound_complex_count = out_counts_ff[SP_BOUND];
   assign rsp_count_saturated     = out_sat_ff;

   // An accepted request always starts with the propensity passes.
   `GSSA_ASSERT_NEXT(a_accept_starts, clock, reset, req_accept, state_ff == S_PROP, "step did not start")
   // A step where nothing fired never reports a clipped count.
   `GSSA_ASSERT_NOW(a_none_no_sat, clock, reset, rsp_valid_ff && (out_index_ff == NONE_FIRED), !out_sat_ff, "saturation without reaction")
   // The divider only runs with a nonzero total propensity.
   `GSSA_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == S_DIV, total_ff != '0, "division by zero total")

endmodule
`default_nettype wire
